// ===== design/downmix_averaging_resampler_macros.svh =====
// assertion macros shared by the resampler modules
`ifndef DOWNMIX_AVERAGING_RESAMPLER_MACROS_SVH
`define DOWNMIX_AVERAGING_RESAMPLER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define DAR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define DAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dar_pkg.sv =====
// types and constants shared by the resampler modules
package dar_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 24;
   localparam int COUNT_W     = 8;
   localparam int PHASE_W     = 18;
   localparam int IN_RATE_W   = 18;
   localparam int OUT_RATE_W  = 15;
   localparam int CHAN_W      = 2;
   localparam int SEQ_W       = 32;
   localparam int RUN_W       = 3;
   localparam int MAX_RUN     = 4;
   localparam int BIT_W       = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 18;

   localparam logic [CHAN_W-1:0]     CHANNEL_COUNT_RESET = 2'd1;
   localparam logic [CHAN_W-1:0]     STEREO              = 2'd2;
   localparam logic [IN_RATE_W-1:0]  INPUT_RATE_RESET    = 18'd48000;
   localparam logic [OUT_RATE_W-1:0] OUTPUT_RATE_RESET   = 15'd16000;

   localparam logic signed [SUM_W-1:0]    SUM_MAX    = 24'sh7FFFFF;
   localparam logic signed [SUM_W-1:0]    SUM_MIN    = -24'sh800000;
   localparam logic [COUNT_W-1:0]         COUNT_MAX  = 8'd255;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;
   localparam logic [SUM_W-1:0]           NEG_LIMIT  = 24'd32768;
   localparam logic [SUM_W-1:0]           POS_LIMIT  = 24'd32767;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT = 2'd0,
      CSR_INPUT_RATE    = 2'd1,
      CSR_OUTPUT_RATE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0]     channel_count;
      logic [IN_RATE_W-1:0]  input_rate;
      logic [OUT_RATE_W-1:0] output_rate;
   } cfg_type;

   // one step's worth of output work
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [COUNT_W-1:0]      count;
      logic [RUN_W-1:0]        run;
   } job_type;

   typedef enum logic {
      FE_IDLE,
      FE_WORK
   } fe_state_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_DIV,
      BE_SAT,
      BE_EMIT
   } be_state_type;

endpackage

// ===== design/downmix_averaging_resampler.sv =====
// top level of the downmixing boxcar-average sample-rate converter
// usage:
//   req_ channel takes one pcm frame per item (left, right); right is used
//   only when channel_count is two. frames are averaged to mono and summed
//   into a boxcar; a phase accumulator steps by output_rate and each time it
//   reaches input_rate the boxcar mean goes out on the rsp_ channel.
//   one input item gives zero to four result items; the last one of a step
//   carries rsp_last_of_run. rsp_sample_number counts results, wrapping.
//   csr_ channel writes channel_count (0), input_rate (1), output_rate (2);
//   other indexes are dropped. csr_ready is always high; write only when idle.
// flow:
//   the front end accepts an item, then does its phase step; it takes no
//   new item until that step's job has gone into the queue. the back end
//   pops a job, runs a one-bit-per-cycle serial divider (skipped when the
//   count is zero), saturates, then loads the results into the output
//   register one at a time; it pops no new job until the last result of
//   the step is loaded.
// reset clears the boxcar, phase, sample count and queue and loads the
// default rates. a stalled receiver fills the output register, then the
// job queue, then req_ready drops.
module downmix_averaging_resampler #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [dar_pkg::SAMPLE_W-1:0]    req_left_sample,
   input  logic signed [dar_pkg::SAMPLE_W-1:0]    req_right_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dar_pkg::SAMPLE_W-1:0]    rsp_ref_sample,
   output logic [dar_pkg::SEQ_W-1:0]              rsp_sample_number,
   output logic                                   rsp_last_of_run,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dar_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [dar_pkg::CSR_DATA_W-1:0]         csr_data
);
   import dar_pkg::*;

   // configuration registers
   logic [CHAN_W-1:0]     channel_count_ff, channel_count_in;
   logic [IN_RATE_W-1:0]  input_rate_ff, input_rate_in;
   logic [OUT_RATE_W-1:0] output_rate_ff, output_rate_in;
   cfg_type               cfg;

   // front to queue, queue to back
   logic                  fq_valid;
   logic                  fq_ready;
   job_type               fq_job;
   logic                  qb_valid;
   logic                  qb_ready;
   job_type               qb_job;

   // writes are always taken; values are masked to register width
   assign csr_ready = 1'b1;

   always_comb begin
      channel_count_in = channel_count_ff;
      input_rate_in    = input_rate_ff;
      output_rate_in   = output_rate_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: channel_count_in = csr_data[CHAN_W-1:0];
            CSR_INPUT_RATE:    input_rate_in    = csr_data[IN_RATE_W-1:0];
            CSR_OUTPUT_RATE:   output_rate_in   = csr_data[OUT_RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CHANNEL_COUNT_RESET;
         input_rate_ff    <= INPUT_RATE_RESET;
         output_rate_ff   <= OUTPUT_RATE_RESET;
      end else begin
         channel_count_ff <= channel_count_in;
         input_rate_ff    <= input_rate_in;
         output_rate_ff   <= output_rate_in;
      end
   end

   assign cfg.channel_count = channel_count_ff;
   assign cfg.input_rate    = input_rate_ff;
   assign cfg.output_rate   = output_rate_ff;

   // downmix, boxcar sum and phase step
   dar_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .job_valid        (fq_valid),
      .job_ready        (fq_ready),
      .job              (fq_job)
   );

   // decouples the phase stepper from the divider
   dar_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_job   (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_job    (qb_job)
   );

   // mean by serial division, then one result per run slot
   dar_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (qb_valid),
      .job_ready         (qb_ready),
      .job               (qb_job),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ref_sample    (rsp_ref_sample),
      .rsp_sample_number (rsp_sample_number),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ===== design/dar_front.sv =====
// front end: downmix, accumulate, phase step and job issue
module dar_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dar_pkg::cfg_type                       cfg,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [dar_pkg::SAMPLE_W-1:0]    req_left_sample,
   input  logic signed [dar_pkg::SAMPLE_W-1:0]    req_right_sample,
   output logic                                   job_valid,
   input  logic                                   job_ready,
   output dar_pkg::job_type                       job
);
   import dar_pkg::*;

   fe_state_type                  state_ff, state_in;
   logic signed [SAMPLE_W-1:0]    mono_ff, mono_in;
   logic [PHASE_W:0]              step_phase_ff, step_phase_in;
   logic [PHASE_W-1:0]            phase_acc_ff, phase_acc_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic [COUNT_W-1:0]            count_ff, count_in;

   logic signed [SAMPLE_W:0]      pair_sum;
   logic signed [SAMPLE_W:0]      pair_adj;
   logic signed [SUM_W:0]         sum_wide;
   logic signed [SUM_W-1:0]       new_sum;
   logic [COUNT_W-1:0]            new_count;
   logic [PHASE_W:0]              phase_left;
   logic [PHASE_W-1:0]            phase_sat;
   logic [RUN_W-1:0]              run;
   logic                          req_fire;
   logic                          job_fire;

   // stereo average, rounded toward zero
   assign pair_sum = {req_left_sample[SAMPLE_W-1], req_left_sample}
                   + {req_right_sample[SAMPLE_W-1], req_right_sample};
   assign pair_adj = pair_sum + $signed({{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]});

   assign sum_wide = {sum_ff[SUM_W-1], sum_ff}
                   + {{(SUM_W-SAMPLE_W+1){mono_ff[SAMPLE_W-1]}}, mono_ff};
   assign new_sum  = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                   ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX)
                   : sum_wide[SUM_W-1:0];
   assign new_count = (count_ff < COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;

   // up to four compare and subtract steps against the input rate
   always_comb begin
      phase_left = step_phase_ff;
      run        = '0;
      for (int k = 0; k < MAX_RUN; k++) begin
         if (phase_left >= {1'b0, cfg.input_rate}) begin
            phase_left = phase_left - {1'b0, cfg.input_rate};
            run        = run + RUN_W'(1);
         end
      end
   end

   assign phase_sat = phase_left[PHASE_W] ? '1 : phase_left[PHASE_W-1:0];

   assign job.sum   = new_sum;
   assign job.count = new_count;
   assign job.run   = run;

   assign req_fire = req_valid && req_ready;
   assign job_fire = job_valid && job_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FE_IDLE: begin
            if (req_valid) state_in = FE_WORK;
         end
         FE_WORK: begin
            if (run == '0 || job_ready) state_in = FE_IDLE;
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      job_valid = 1'b0;
      unique case (state_ff)
         FE_IDLE: req_ready = 1'b1;
         FE_WORK: job_valid = (run != '0);
         default: ;
      endcase
   end

   always_comb begin
      mono_in       = mono_ff;
      step_phase_in = step_phase_ff;
      phase_acc_in  = phase_acc_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      if (req_fire) begin
         mono_in       = (cfg.channel_count == STEREO) ? pair_adj[SAMPLE_W:1]
                                                       : req_left_sample;
         step_phase_in = {1'b0, phase_acc_ff}
                       + {{(PHASE_W+1-OUT_RATE_W){1'b0}}, cfg.output_rate};
      end
      if (state_ff == FE_WORK) begin
         if (run == '0) begin
            sum_in       = new_sum;
            count_in     = new_count;
            phase_acc_in = phase_sat;
         end else if (job_fire) begin
            sum_in       = '0;
            count_in     = '0;
            phase_acc_in = phase_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FE_IDLE;
         phase_acc_ff <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         phase_acc_ff <= phase_acc_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mono_ff       <= mono_in;
      step_phase_ff <= step_phase_in;
   end

endmodule

// ===== design/dar_queue.sv =====
// short job queue between front and back
module dar_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  dar_pkg::job_type  push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output dar_pkg::job_type  pop_job
);
   import dar_pkg::*;

   `include "downmix_averaging_resampler_macros.svh"

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   job_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                push_fire;
   logic                pop_fire;

   assign push_ready = (fill_ff != FILL_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop_fire) fill_in = fill_ff + FILL_W'(1);
      if (pop_fire && !push_fire) fill_in = fill_ff - FILL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) slot_ff[wr_ptr_ff] <= push_job;
   end

   `DAR_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(DEPTH), "queue overfilled")
   `DAR_ASSERT_NEXT(a_fill_grow, clock, reset, push_fire && !pop_fire, fill_ff == $past(fill_ff) + FILL_W'(1), "queue fill did not grow")

endmodule

// ===== design/dar_back.sv =====
// back end: serial divide, saturate and result issue
module dar_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   job_valid,
   output logic                                   job_ready,
   input  dar_pkg::job_type                       job,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dar_pkg::SAMPLE_W-1:0]    rsp_ref_sample,
   output logic [dar_pkg::SEQ_W-1:0]              rsp_sample_number,
   output logic                                   rsp_last_of_run
);
   import dar_pkg::*;

   `include "downmix_averaging_resampler_macros.svh"

   be_state_type                state_ff, state_in;
   logic                        neg_ff, neg_in;
   logic [COUNT_W-1:0]          divisor_ff, divisor_in;
   logic [SUM_W-1:0]            dividend_ff, dividend_in;
   logic [COUNT_W-1:0]          rem_ff, rem_in;
   logic [BIT_W-1:0]            bit_ff, bit_in;
   logic signed [SAMPLE_W-1:0]  quot_ff, quot_in;
   logic [RUN_W-1:0]            remain_ff, remain_in;
   logic                        first_ff, first_in;
   logic [SEQ_W-1:0]            seq_ff, seq_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic [SEQ_W-1:0]            rsp_number_ff, rsp_number_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        job_fire;
   logic                        emit_load;
   logic [COUNT_W:0]            trial;
   logic                        trial_ge;
   logic [COUNT_W:0]            trial_diff;
   logic [SUM_W-1:0]            abs_sum;
   logic [SUM_W-1:0]            neg_quot;

   assign job_fire   = job_valid && job_ready;
   assign trial      = {rem_ff, dividend_ff[SUM_W-1]};
   assign trial_ge   = (trial >= {1'b0, divisor_ff});
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign abs_sum    = job.sum[SUM_W-1] ? (~job.sum + SUM_W'(1)) : job.sum;
   assign neg_quot   = ~dividend_ff + SUM_W'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BE_IDLE: begin
            if (job_valid) state_in = (job.count == '0) ? BE_EMIT : BE_DIV;
         end
         BE_DIV: begin
            if (bit_ff == '0) state_in = BE_SAT;
         end
         BE_SAT: state_in = BE_EMIT;
         BE_EMIT: begin
            if (emit_load && remain_ff == RUN_W'(1)) state_in = BE_IDLE;
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_comb begin
      job_ready = 1'b0;
      emit_load = 1'b0;
      unique case (state_ff)
         BE_IDLE: job_ready = 1'b1;
         BE_EMIT: emit_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_comb begin
      neg_in        = neg_ff;
      divisor_in    = divisor_ff;
      dividend_in   = dividend_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      quot_in       = quot_ff;
      remain_in     = remain_ff;
      first_in      = first_ff;
      seq_in        = seq_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_number_in = rsp_number_ff;
      rsp_last_in   = rsp_last_ff;
      if (job_fire) begin
         neg_in      = job.sum[SUM_W-1];
         divisor_in  = job.count;
         dividend_in = abs_sum;
         rem_in      = '0;
         bit_in      = BIT_W'(SUM_W - 1);
         quot_in     = '0;
         remain_in   = job.run;
         first_in    = 1'b1;
      end
      if (state_ff == BE_DIV) begin
         rem_in      = trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
         dividend_in = {dividend_ff[SUM_W-2:0], trial_ge};
         bit_in      = bit_ff - BIT_W'(1);
      end
      if (state_ff == BE_SAT) begin
         if (neg_ff) begin
            quot_in = (dividend_ff > NEG_LIMIT) ? SAMPLE_MIN : neg_quot[SAMPLE_W-1:0];
         end else begin
            quot_in = (dividend_ff > POS_LIMIT) ? SAMPLE_MAX : dividend_ff[SAMPLE_W-1:0];
         end
      end
      if (emit_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = first_ff ? quot_ff : '0;
         rsp_number_in = seq_ff;
         rsp_last_in   = (remain_ff == RUN_W'(1));
         seq_in        = seq_ff + SEQ_W'(1);
         remain_in     = remain_ff - RUN_W'(1);
         first_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         remain_ff    <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff        <= neg_in;
      divisor_ff    <= divisor_in;
      dividend_ff   <= dividend_in;
      rem_ff        <= rem_in;
      bit_ff        <= bit_in;
      quot_ff       <= quot_in;
      first_ff      <= first_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_number_ff <= rsp_number_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ref_sample    = rsp_sample_ff;
   assign rsp_sample_number = rsp_number_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   `DAR_ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == BE_DIV, divisor_ff != '0, "divide by zero count")
   `DAR_ASSERT_NOW(a_emit_pending, clock, reset, state_ff == BE_EMIT, remain_ff != '0, "emit with no results left")

endmodule

// ===== bench/downmix_averaging_resampler_tb.sv =====
// self-checking bench for the downmixing boxcar-average resampler: directed table, then random
`timescale 1ns / 1ps

module downmix_averaging_resampler_tb;
   import dar_pkg::*;

   // index with no register behind it, writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int PHASE_LIMIT   = 2**PHASE_W - 1;
   localparam int SETTLE_CYCLES = 40;   // front end plus divider, with margin
   localparam int HOLD_CYCLES   = 300;  // long receiver stall, fills the job queue
   localparam int RANDOM_FRAMES = 195;
   localparam int CALM_FRAMES   = 40;   // last stretch runs with no idling at all

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] ref_sample;
      logic [SEQ_W-1:0]           sample_number;
      logic                       last_of_run;
   } mono_out_type;

   typedef enum logic {
      ROW_FRAME,
      ROW_WRITE
   } row_kind_type;

   // how a table row is checked: by the predictor, or by a value typed in below
   typedef enum logic [1:0] {
      BY_MODEL,
      NO_OUTPUT,
      ONE_OUTPUT
   } check_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_W-1:0]     index;
      logic [CSR_DATA_W-1:0]      data;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      check_kind_type             check;
      logic signed [SAMPLE_W-1:0] typed_sample;
      logic [SEQ_W-1:0]           typed_number;
   } row_type;

   localparam int DIRECTED_COUNT = 32;
   localparam row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // reset rates 48000 / 16000, one channel: every third frame closes a boxcar
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, NO_OUTPUT, '0, '0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MAX, NO_OUTPUT, '0, '0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, 16'sd0, ONE_OUTPUT, SAMPLE_MAX, 32'd0},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, SAMPLE_MAX, NO_OUTPUT, '0, '0},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, 16'sd0, NO_OUTPUT, '0, '0},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, -16'sd1, ONE_OUTPUT, SAMPLE_MIN, 32'd1},
      // two channels, junk in the upper data bits must be masked off
      '{ROW_WRITE, CSR_CHANNEL_COUNT, 18'h3FFFE, '0, '0, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, -16'sd32767, BY_MODEL, '0, '0},
      // odd sums truncate toward zero, not toward minus infinity
      '{ROW_FRAME, '0, '0, -16'sd3, 16'sd0, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MAX, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, 16'sd5, -16'sd2, BY_MODEL, '0, '0},
      // channel counts three and zero fall back to left only
      '{ROW_WRITE, CSR_CHANNEL_COUNT, 18'd3, '0, '0, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, 16'sd100, SAMPLE_MAX, BY_MODEL, '0, '0},
      '{ROW_WRITE, CSR_CHANNEL_COUNT, 18'd0, '0, '0, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, -16'sd100, SAMPLE_MIN, BY_MODEL, '0, '0},
      // write to the spare index is dropped
      '{ROW_WRITE, CSR_UNUSED, 18'h3FFFF, '0, '0, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, 16'sd7, 16'sd7, BY_MODEL, '0, '0},
      // heavy upsampling: four results per frame, the later ones average nothing
      '{ROW_WRITE, CSR_INPUT_RATE, 18'd1000, '0, '0, BY_MODEL, '0, '0},
      '{ROW_WRITE, CSR_OUTPUT_RATE, 18'h3FFFF, '0, '0, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, 16'sd1234, 16'sd0, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, -16'sd1234, 16'sd0, BY_MODEL, '0, '0},
      // zero input rate: capped at four per frame while the phase climbs to its ceiling
      '{ROW_WRITE, CSR_INPUT_RATE, 18'd0, '0, '0, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, 16'sd1, 16'sd0, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, SAMPLE_MAX, SAMPLE_MIN, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, SAMPLE_MIN, SAMPLE_MAX, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, 16'sh5555, -16'sd21846, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, -16'sd21846, 16'sh5555, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, -16'sd1, SAMPLE_MAX, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, 16'sd0, -16'sd1, BY_MODEL, '0, '0},
      // widest input rate, slowest output rate: drains the saturated phase once
      '{ROW_WRITE, CSR_INPUT_RATE, 18'h3FFFF, '0, '0, BY_MODEL, '0, '0},
      '{ROW_WRITE, CSR_OUTPUT_RATE, 18'd1000, '0, '0, BY_MODEL, '0, '0},
      '{ROW_FRAME, '0, '0, 16'sd42, 16'sd0, BY_MODEL, '0, '0}
   };

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [SAMPLE_W-1:0]   req_left_sample;
   logic signed [SAMPLE_W-1:0]   req_right_sample;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [SAMPLE_W-1:0]   rsp_ref_sample;
   logic [SEQ_W-1:0]             rsp_sample_number;
   logic                         rsp_last_of_run;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_INDEX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]        csr_data;

   // predictor state: register copies and the boxcar itself
   logic [CHAN_W-1:0]            model_channels;
   logic [IN_RATE_W-1:0]         model_in_rate;
   logic [OUT_RATE_W-1:0]        model_out_rate;
   logic [PHASE_W-1:0]           model_phase;
   logic signed [SUM_W-1:0]      model_sum;
   logic [COUNT_W-1:0]           model_count;
   logic [SEQ_W-1:0]             model_emitted;

   mono_out_type                 awaited_samples [$];
   int                           mismatches;
   bit                           calm_tail;
   bit                           hold_rsp_request;

   downmix_averaging_resampler dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_sample   (req_left_sample),
      .req_right_sample  (req_right_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ref_sample    (rsp_ref_sample),
      .rsp_sample_number (rsp_sample_number),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // generous wall: the slowest legal run is well under a tenth of this
   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // one frame through the boxcar; fills outs and returns how many results it makes
   function automatic int boxcar_step(input logic signed [SAMPLE_W-1:0] left,
                                      input logic signed [SAMPLE_W-1:0] right,
                                      output mono_out_type outs [MAX_RUN]);
      int mono;
      int total;
      int phase;
      int quotient;
      int n;
      n = 0;
      foreach (outs[i]) outs[i] = '0;
      mono = (model_channels == STEREO) ? (int'(left) + int'(right)) / 2 : int'(left);
      total = int'(model_sum) + mono;
      if (total > int'(SUM_MAX)) total = int'(SUM_MAX);
      else if (total < int'(SUM_MIN)) total = int'(SUM_MIN);
      model_sum = total[SUM_W-1:0];
      if (model_count != COUNT_MAX) model_count++;
      phase = int'(model_phase) + int'(model_out_rate);
      while (phase >= int'(model_in_rate) && n < MAX_RUN) begin
         phase -= int'(model_in_rate);
         quotient = 0;
         if (model_count != '0) begin
            quotient = int'(model_sum) / int'(model_count);
            if (quotient > int'(SAMPLE_MAX)) quotient = int'(SAMPLE_MAX);
            else if (quotient < int'(SAMPLE_MIN)) quotient = int'(SAMPLE_MIN);
         end
         outs[n].ref_sample    = quotient[SAMPLE_W-1:0];
         outs[n].sample_number = model_emitted;
         outs[n].last_of_run   = 1'b0;
         model_emitted++;
         model_sum   = '0;
         model_count = '0;
         n++;
      end
      if (n > 0) outs[n-1].last_of_run = 1'b1;
      model_phase = (phase > PHASE_LIMIT) ? '1 : phase[PHASE_W-1:0];
      return n;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SAMPLE_W'($urandom_range(0, 16) - 8);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic void note_mismatch(input string field, input longint want,
                                         input longint got);
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatches++;
   endfunction

   // drop valid, wait for every awaited sample, then let a trailing step settle
   task automatic await_idle();
      req_valid <= 1'b0;
      while (awaited_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      await_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_CHANNEL_COUNT: model_channels = data[CHAN_W-1:0];
         CSR_INPUT_RATE:    model_in_rate  = data[IN_RATE_W-1:0];
         CSR_OUTPUT_RATE:   model_out_rate = data[OUT_RATE_W-1:0];
         default: ;
      endcase
   endtask

   // offer one frame; valid stays up afterwards unless the next item brings a gap
   task automatic offer_frame(input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right,
                              input check_kind_type check,
                              input logic signed [SAMPLE_W-1:0] typed_sample,
                              input logic [SEQ_W-1:0] typed_number);
      mono_out_type outs [MAX_RUN];
      int n;
      if (!calm_tail && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_left_sample  <= left;
      req_right_sample <= right;
      do @(posedge clock); while (!req_ready);
      // predictor always advances, typed rows only replace what gets awaited
      n = boxcar_step(left, right, outs);
      case (check)
         NO_OUTPUT: ;
         ONE_OUTPUT: awaited_samples.push_back('{typed_sample, typed_number, 1'b1});
         default: for (int i = 0; i < n; i++) awaited_samples.push_back(outs[i]);
      endcase
   endtask

   // receiver: random ready bursts, a long hold on request, steady at the end
   initial begin
      int span;
      logic ready_next;
      forever begin
         if (hold_rsp_request) begin
            ready_next = 1'b0;
            span = HOLD_CYCLES;
            hold_rsp_request = 1'b0;
         end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
            ready_next = 1'b0;
            span = $urandom_range(1, 11);
         end else begin
            ready_next = 1'b1;
            span = $urandom_range(1, 16);
         end
         rsp_ready <= ready_next;
         repeat (span) @(posedge clock);
      end
   end

   // result checker: each accepted item against the oldest awaited sample
   always @(posedge clock) begin
      mono_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_samples.size() == 0) begin
            $display("%0t: ref_sample expected none got %0d", $time, rsp_ref_sample);
            mismatches++;
         end else begin
            want = awaited_samples.pop_front();
            if (rsp_ref_sample !== want.ref_sample)
               note_mismatch("ref_sample", want.ref_sample, rsp_ref_sample);
            if (rsp_sample_number !== want.sample_number)
               note_mismatch("sample_number", want.sample_number, rsp_sample_number);
            if (rsp_last_of_run !== want.last_of_run)
               note_mismatch("last_of_run", want.last_of_run, rsp_last_of_run);
         end
      end
   end

   initial begin
      int random_frames;
      int burst;
      int round;
      logic [IN_RATE_W-1:0]  in_rate;
      logic [OUT_RATE_W-1:0] out_rate;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_left_sample  <= '0;
      req_right_sample <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= '0;
      csr_data         <= '0;
      mismatches       = 0;
      calm_tail        = 1'b0;
      hold_rsp_request = 1'b0;
      model_channels   = CHANNEL_COUNT_RESET;
      model_in_rate    = INPUT_RATE_RESET;
      model_out_rate   = OUTPUT_RATE_RESET;
      model_phase      = '0;
      model_sum        = '0;
      model_count      = '0;
      model_emitted    = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table, straight out of reset
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_WRITE)
            write_reg(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].data);
         else
            offer_frame(DIRECTED_ROWS[i].left, DIRECTED_ROWS[i].right, DIRECTED_ROWS[i].check,
                        DIRECTED_ROWS[i].typed_sample, DIRECTED_ROWS[i].typed_number);
      end

      // random rounds, each under its own register setting
      random_frames = 0;
      round = 0;
      while (random_frames < RANDOM_FRAMES) begin
         if (round == 1) begin
            // one result per frame while the receiver sits out a long stall
            write_reg(CSR_INPUT_RATE, 18'd16000);
            write_reg(CSR_OUTPUT_RATE, 18'd16000);
            hold_rsp_request = 1'b1;
            burst = 24;
         end else begin
            if ($urandom_range(0, 2) != 0)
               write_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'($urandom));
            if ($urandom_range(0, 2) != 0) begin
               case ($urandom_range(0, 9))
                  0: in_rate = 18'd8000;
                  1: in_rate = 18'd192000;
                  2: in_rate = IN_RATE_W'($urandom_range(1, 4000));
                  3: in_rate = ($urandom_range(0, 1) != 0) ? '1 : '0;
                  default: in_rate = IN_RATE_W'($urandom_range(8000, 192000));
               endcase
               write_reg(CSR_INPUT_RATE, in_rate);
            end
            if ($urandom_range(0, 2) != 0) begin
               case ($urandom_range(0, 7))
                  0: out_rate = 15'd1000;
                  1: out_rate = 15'd32000;
                  2: out_rate = OUT_RATE_W'($urandom);
                  default: out_rate = OUT_RATE_W'($urandom_range(1000, 32000));
               endcase
               // upper data bits are junk, only the low 15 may land
               write_reg(CSR_OUTPUT_RATE, {3'($urandom), out_rate});
            end
            burst = $urandom_range(8, 30);
         end
         repeat (burst) begin
            if (random_frames >= RANDOM_FRAMES - CALM_FRAMES) calm_tail = 1'b1;
            offer_frame(random_sample(), random_sample(), BY_MODEL, '0, '0);
            random_frames++;
         end
         round++;
      end

      await_idle();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
